@@ src/swl_pkg.sv @@
// shared types and constants of the stopwatch with lap store
// no dependencies
package swl_pkg;

  localparam logic [2:0] CMD_LAP   = 3'd0;
  localparam logic [2:0] CMD_LIST  = 3'd1;
  localparam logic [2:0] CMD_START = 3'd2;
  localparam logic [2:0] CMD_STOP  = 3'd3;
  localparam logic [2:0] CMD_RESET = 3'd4;

  localparam logic OPER_TICK = 1'b0;

  localparam logic [7:0] DEBOUNCE_RESET = 8'd20;
  localparam logic [9:0] MS_PER_SEC     = 10'd1000;
  localparam logic [5:0] SEC_PER_MIN    = 6'd60;
  localparam logic [5:0] MIN_PER_HOUR   = 6'd60;
  localparam logic [6:0] HOUR_WRAP      = 7'd100;

  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [2:0] {
    OP_TICK,
    OP_LAP,
    OP_LIST,
    OP_START,
    OP_STOP,
    OP_RESET
  } op_kind_t;

  typedef struct packed {
    op_kind_t kind;
    logic     level;
  } op_t;

  typedef enum logic [3:0] {
    RK_TIME       = 4'd0,
    RK_BTN_START  = 4'd1,
    RK_BTN_STOP   = 4'd2,
    RK_STARTED    = 4'd3,
    RK_STOPPED    = 4'd4,
    RK_LAP_SAVED  = 4'd5,
    RK_LAP_FULL   = 4'd6,
    RK_RESET      = 4'd7,
    RK_LIST_HDR   = 4'd8,
    RK_LAP_ENTRY  = 4'd9,
    RK_LIST_EMPTY = 4'd10
  } report_kind_t;

  typedef struct packed {
    logic [6:0] h;
    logic [5:0] m;
    logic [5:0] s;
  } lap_entry_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_BUTTON,
    BK_EMPTY,
    BK_ENTRY
  } back_state_t;

endpackage

@@ src/stopwatch_with_lap_store.sv @@
// top level of the stopwatch with lap store
// depends on swl_pkg, swl_front, swl_queue, swl_back
//
// input: an item is taken at a clock edge with start high and busy low;
//   operation 0 is a millisecond tick carrying button_level, operation 1 a
//   command in command_code (lap, list laps, start, stop, reset)
// config: cfg_wr_data is written to the debounce threshold at an edge with
//   cfg_wr_en high
// output: each result is on the result ports for one cycle with strobe high;
//   last marks the final result of an item
// path: an item passes the front register, the queue and the back end's
//   output registers, and waits in the queue while the back end is busy
// throughput: single-result items stream at one per cycle while no other
//   item holds the back end; a lap listing holds it while it sends the header
//   and then each stored lap entry, or the empty report when no lap is
//   stored, and a tick with a time and a button report while it sends both;
//   busy rises when the queue and front register are full
// reset: time, run state, debounce, lap count cleared, threshold back to 20
// the receiver cannot stall; results are never held back
module stopwatch_with_lap_store #(
  parameter int MAX_LAPS = 10
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic       operation,
  input  logic       button_level,
  input  logic [2:0] command_code,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data,
  output logic       strobe,
  output logic [3:0] report_kind,
  output logic [6:0] hours,
  output logic [5:0] minutes,
  output logic [5:0] seconds,
  output logic [5:0] lap_index,
  output logic       last
);
  import swl_pkg::*;

  logic q_full;
  logic push;
  op_t  push_op;
  logic pop;
  logic q_valid;
  op_t  q_head;

  swl_front u_front (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .operation    (operation),
    .button_level (button_level),
    .command_code (command_code),
    .q_full       (q_full),
    .busy         (busy),
    .push         (push),
    .push_op      (push_op)
  );

  swl_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_op (push_op),
    .pop     (pop),
    .full    (q_full),
    .valid   (q_valid),
    .head    (q_head)
  );

  swl_back #(
    .MAX_LAPS (MAX_LAPS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_op        (q_head),
    .pop         (pop),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .strobe      (strobe),
    .report_kind (report_kind),
    .hours       (hours),
    .minutes     (minutes),
    .seconds     (seconds),
    .lap_index   (lap_index),
    .last        (last)
  );

endmodule

@@ src/swl_front.sv @@
// front end: accepts items, classifies them into operations
// depends on swl_pkg
module swl_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic           operation,
  input  logic           button_level,
  input  logic [2:0]     command_code,
  input  logic           q_full,
  output logic           busy,
  output logic           push,
  output swl_pkg::op_t   push_op
);
  import swl_pkg::*;

  logic op_valid;
  logic op_valid_next;
  op_t  op;
  op_t  op_class;
  logic known;
  logic accept;

  assign busy    = op_valid & q_full;
  assign accept  = start & ~busy;
  assign push    = op_valid & ~q_full;
  assign push_op = op;

  always_comb begin
    op_class.level = button_level;
    op_class.kind  = OP_TICK;
    known          = 1'b1;
    if (operation != OPER_TICK) begin
      unique case (command_code)
        CMD_LAP:   op_class.kind = OP_LAP;
        CMD_LIST:  op_class.kind = OP_LIST;
        CMD_START: op_class.kind = OP_START;
        CMD_STOP:  op_class.kind = OP_STOP;
        CMD_RESET: op_class.kind = OP_RESET;
        default:   known = 1'b0;
      endcase
    end
  end

  assign op_valid_next = (accept & known) | (op_valid & q_full);

  always_ff @(posedge clk) begin
    if (rst) begin
      op_valid <= 1'b0;
    end else begin
      op_valid <= op_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op <= op_class;
    end
  end

endmodule

@@ src/swl_queue.sv @@
// short operation queue between front and back end
// depends on swl_pkg
module swl_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  swl_pkg::op_t   push_op,
  input  logic           pop,
  output logic           full,
  output logic           valid,
  output swl_pkg::op_t   head
);
  import swl_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  op_t           entries [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] fill;
  logic          do_push;
  logic          do_pop;

  assign full    = (fill == CW'(QUEUE_DEPTH));
  assign valid   = (fill != '0);
  assign head    = entries[rd_ptr];
  assign do_push = push & ~full;
  assign do_pop  = pop & valid;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    logic [PW-1:0] r;
    if (p == PW'(QUEUE_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + PW'(1);
    end
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (do_pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (do_push & ~do_pop) begin
        fill <= fill + CW'(1);
      end else if (do_pop & ~do_push) begin
        fill <= fill - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_op;
    end
  end

endmodule

@@ src/swl_back.sv @@
// back end: time keeping, debounce, lap store and result sequencing
// depends on swl_pkg
module swl_back #(
  parameter int MAX_LAPS = 10
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_valid,
  input  swl_pkg::op_t   q_op,
  output logic           pop,
  input  logic           cfg_wr_en,
  input  logic [7:0]     cfg_wr_data,
  output logic           strobe,
  output logic [3:0]     report_kind,
  output logic [6:0]     hours,
  output logic [5:0]     minutes,
  output logic [5:0]     seconds,
  output logic [5:0]     lap_index,
  output logic           last
);
  import swl_pkg::*;

  localparam int AW  = (MAX_LAPS > 1) ? $clog2(MAX_LAPS) : 1;
  localparam int LTW = $clog2(MAX_LAPS + 1);
  localparam logic [LTW-1:0] LAPS_MAX = LTW'(MAX_LAPS);

  back_state_t state, state_next;

  logic [7:0]     debounce_ticks;
  logic           run_flag, run_flag_next;
  logic [9:0]     millis_count, millis_count_next;
  logic [5:0]     seconds_count, seconds_count_next;
  logic [5:0]     minutes_count, minutes_count_next;
  logic [6:0]     hours_count, hours_count_next;
  logic [7:0]     debounce_count, debounce_count_next;
  logic           press_latched, press_latched_next;
  logic [LTW-1:0] lap_total, lap_total_next;
  logic [LTW-1:0] cnt, cnt_next;
  logic [LTW-1:0] cnt_inc;

  logic           strobe_next;
  report_kind_t   kind_next;
  logic [6:0]     hours_next;
  logic [5:0]     minutes_next;
  logic [5:0]     seconds_next;
  logic [5:0]     lap_index_next;
  logic           last_next;

  lap_entry_t     lap_store [MAX_LAPS];
  lap_entry_t     rd_data;
  logic [AW-1:0]  rd_addr;
  logic           wr_en;

  logic [8:0]     dc_inc;
  logic           fire;
  logic           roll;
  logic [9:0]     ms_inc;
  logic [5:0]     s_t;
  logic [5:0]     m_t;
  logic [6:0]     h_t;
  logic           entry_last;

  assign pop        = (state == BK_IDLE) & q_valid;
  assign cnt_inc    = cnt + LTW'(1);
  assign entry_last = (cnt_inc == lap_total);
  assign rd_addr    = (state == BK_ENTRY && cnt_inc < LAPS_MAX) ? AW'(cnt_inc) : '0;
  assign wr_en      = pop & (q_op.kind == OP_LAP) & (lap_total < LAPS_MAX);

  // debounce and time advance for a tick
  always_comb begin
    dc_inc              = {1'b0, debounce_count} + 9'd1;
    fire                = 1'b0;
    debounce_count_next = debounce_count;
    press_latched_next  = press_latched;
    if (q_op.level) begin
      if (dc_inc >= {1'b0, debounce_ticks}) begin
        fire                = ~press_latched;
        press_latched_next  = 1'b1;
        debounce_count_next = debounce_ticks;
      end else begin
        debounce_count_next = dc_inc[7:0];
      end
    end else begin
      debounce_count_next = '0;
      press_latched_next  = 1'b0;
    end

    ms_inc = millis_count + 10'd1;
    roll   = run_flag & (ms_inc >= MS_PER_SEC);
    s_t    = seconds_count;
    m_t    = minutes_count;
    h_t    = hours_count;
    if (roll) begin
      s_t = seconds_count + 6'd1;
      if (s_t >= SEC_PER_MIN) begin
        s_t = '0;
        m_t = minutes_count + 6'd1;
      end
      if (m_t >= MIN_PER_HOUR) begin
        m_t = '0;
        h_t = hours_count + 7'd1;
      end
      if (h_t >= HOUR_WRAP) begin
        h_t = '0;
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE: begin
        if (q_valid) begin
          if (q_op.kind == OP_TICK && roll && fire) begin
            state_next = BK_BUTTON;
          end else if (q_op.kind == OP_LIST) begin
            state_next = (lap_total == '0) ? BK_EMPTY : BK_ENTRY;
          end
        end
      end
      BK_BUTTON: state_next = BK_IDLE;
      BK_EMPTY:  state_next = BK_IDLE;
      BK_ENTRY: begin
        if (entry_last) begin
          state_next = BK_IDLE;
        end
      end
      default:   state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    run_flag_next      = run_flag;
    millis_count_next  = millis_count;
    seconds_count_next = seconds_count;
    minutes_count_next = minutes_count;
    hours_count_next   = hours_count;
    lap_total_next     = lap_total;
    cnt_next           = cnt;
    strobe_next        = 1'b0;
    kind_next          = RK_TIME;
    hours_next         = '0;
    minutes_next       = '0;
    seconds_next       = '0;
    lap_index_next     = '0;
    last_next          = 1'b1;
    unique case (state)
      BK_IDLE: begin
        if (q_valid) begin
          unique case (q_op.kind)
            OP_TICK: begin
              if (run_flag) begin
                millis_count_next  = roll ? '0 : ms_inc;
                seconds_count_next = s_t;
                minutes_count_next = m_t;
                hours_count_next   = h_t;
              end
              if (fire) begin
                run_flag_next = ~run_flag;
              end
              if (roll) begin
                strobe_next  = 1'b1;
                hours_next   = h_t;
                minutes_next = m_t;
                seconds_next = s_t;
                last_next    = ~fire;
              end else if (fire) begin
                strobe_next = 1'b1;
                kind_next   = run_flag ? RK_BTN_STOP : RK_BTN_START;
              end
            end
            OP_LAP: begin
              strobe_next = 1'b1;
              if (lap_total < LAPS_MAX) begin
                lap_total_next = lap_total + LTW'(1);
                kind_next      = RK_LAP_SAVED;
              end else begin
                kind_next = RK_LAP_FULL;
              end
            end
            OP_LIST: begin
              run_flag_next = 1'b0;
              strobe_next   = 1'b1;
              kind_next     = RK_LIST_HDR;
              last_next     = 1'b0;
              cnt_next      = '0;
            end
            OP_START: begin
              run_flag_next = 1'b1;
              strobe_next   = 1'b1;
              kind_next     = RK_STARTED;
            end
            OP_STOP: begin
              run_flag_next = 1'b0;
              strobe_next   = 1'b1;
              kind_next     = RK_STOPPED;
            end
            OP_RESET: begin
              run_flag_next      = 1'b0;
              millis_count_next  = '0;
              seconds_count_next = '0;
              minutes_count_next = '0;
              hours_count_next   = '0;
              lap_total_next     = '0;
              strobe_next        = 1'b1;
              kind_next          = RK_RESET;
            end
            default: begin
              strobe_next = 1'b0;
            end
          endcase
        end
      end
      BK_BUTTON: begin
        strobe_next = 1'b1;
        kind_next   = run_flag ? RK_BTN_START : RK_BTN_STOP;
      end
      BK_EMPTY: begin
        strobe_next = 1'b1;
        kind_next   = RK_LIST_EMPTY;
      end
      BK_ENTRY: begin
        strobe_next    = 1'b1;
        kind_next      = RK_LAP_ENTRY;
        hours_next     = rd_data.h;
        minutes_next   = rd_data.m;
        seconds_next   = rd_data.s;
        lap_index_next = 6'(cnt);
        last_next      = entry_last;
        cnt_next       = cnt_inc;
      end
      default: begin
        strobe_next = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= BK_IDLE;
      debounce_ticks <= DEBOUNCE_RESET;
      run_flag       <= 1'b0;
      millis_count   <= '0;
      seconds_count  <= '0;
      minutes_count  <= '0;
      hours_count    <= '0;
      debounce_count <= '0;
      press_latched  <= 1'b0;
      lap_total      <= '0;
      cnt            <= '0;
      strobe         <= 1'b0;
    end else begin
      state         <= state_next;
      run_flag      <= run_flag_next;
      millis_count  <= millis_count_next;
      seconds_count <= seconds_count_next;
      minutes_count <= minutes_count_next;
      hours_count   <= hours_count_next;
      lap_total     <= lap_total_next;
      cnt           <= cnt_next;
      strobe        <= strobe_next;
      if (cfg_wr_en) begin
        debounce_ticks <= cfg_wr_data;
      end
      if (pop && q_op.kind == OP_TICK) begin
        debounce_count <= debounce_count_next;
        press_latched  <= press_latched_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    report_kind <= kind_next;
    hours       <= hours_next;
    minutes     <= minutes_next;
    seconds     <= seconds_next;
    lap_index   <= lap_index_next;
    last        <= last_next;
  end

  // lap memory
  always_ff @(posedge clk) begin
    if (wr_en) begin
      lap_store[AW'(lap_total)] <= '{h: hours_count, m: minutes_count, s: seconds_count};
    end
    rd_data <= lap_store[rd_addr];
  end

endmodule
